// ----- hdl/hmq_pkg.sv -----
// Shared types and constants for the Huffman merge queue.
// Used by hmq_ctrl, hmq_dp, huffman_merge_queue_unit, hmq_checker and the testbench; no dependencies.
package hmq_pkg;

  localparam int unsigned MAX_LEAVES_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF = 32;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned FREQ_W = 32;
  localparam int unsigned RIDX_W = 8;
  localparam int unsigned NODE_W = 9;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned GRP    = 16;
  localparam int unsigned GRP_W  = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_MERGE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_FEW   = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic    capture;
    logic    load;
    logic    plain;
    status_e plain_code;
    logic    mrg_sum;
    logic    mrg_cmp;
    logic    mrg_pfx;
    logic    mrg_ins;
    logic    rd_grp;
    logic    rd_sel;
    logic    emit;
  } hmq_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            few;
    logic            range_err;
    logic            out_free;
  } hmq_stat_t;

  typedef struct packed {
    status_e           status;
    logic [NODE_W-1:0] left;
    logic [NODE_W-1:0] right;
    logic [NODE_W-1:0] node;
    logic [FREQ_W-1:0] freq;
    logic [LEN_W-1:0]  length;
    logic              last;
  } hmq_res_t;

endpackage

// ----- hdl/huffman_merge_queue_unit.sv -----
// Huffman merge queue top level: stream ports, packing, hmq_ctrl and hmq_dp.
// Depends on hmq_pkg, hmq_ctrl, hmq_dp.
// Each item is decoded; load, errors and op 3 then respond, a read adds a group select
// step, and a merge adds compare, prefix-search and shift-insert steps after the sum.
// One item at a time; the next item is taken in the cycle its result is handed to the
// output register, and the handover waits until that register is free.
// Reset empties the list and clears the node counter; cells are not cleared.
module huffman_merge_queue_unit #(
  parameter int unsigned MAX_LEAVES = hmq_pkg::MAX_LEAVES_DEF,
  parameter int unsigned COUNT_BITS = hmq_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // leaf_symbol, leaf_frequency, read_index
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // left_node, right_node, entry_node,
                                     // entry_frequency, list_length, zero pad
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast   // last_merge
);

  hmq_pkg::hmq_cmd_t  cmd;
  hmq_pkg::hmq_stat_t stat;
  hmq_pkg::hmq_res_t  res;

  hmq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hmq_dp #(
    .MAX_LEAVES (MAX_LEAVES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser),
    .in_sym_i    (s_axis_tdata[7:0]),
    .in_freq_i   (s_axis_tdata[39:8]),
    .in_idx_i    (s_axis_tdata[47:40]),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, res.length, res.freq, res.node, res.right, res.left};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.length <= hmq_pkg::LEN_W'(MAX_LEAVES)))
    else $error("list length beyond capacity");

  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (res.status == hmq_pkg::ST_OK && res.length == hmq_pkg::LEN_W'(1)))
    else $error("root flag without a single remaining entry");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.status != hmq_pkg::ST_OK) |->
      (res.left == '0 && res.right == '0 && res.node == '0 && res.freq == '0 && !res.last))
    else $error("error result carries data");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while one is in progress");

endmodule

// ----- hdl/hmq_ctrl.sv -----
// Sequencer for the Huffman merge queue: decodes each item and steps
// the datapath through load, merge and read. Depends on hmq_pkg.
module hmq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hmq_pkg::hmq_stat_t  stat_i,
  output hmq_pkg::hmq_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CMP,
    S_PFX,
    S_INS,
    S_RSEL,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        unique case (hmq_pkg::op_e'(stat_i.op))
          hmq_pkg::OP_LOAD: begin
            if (stat_i.full) begin
              cmd_o.plain      = 1'b1;
              cmd_o.plain_code = hmq_pkg::ST_FULL;
            end else begin
              cmd_o.load = 1'b1;
            end
          end
          hmq_pkg::OP_MERGE: begin
            if (stat_i.few) begin
              cmd_o.plain      = 1'b1;
              cmd_o.plain_code = hmq_pkg::ST_FEW;
            end else begin
              cmd_o.mrg_sum = 1'b1;
              state_d       = S_CMP;
            end
          end
          hmq_pkg::OP_READ: begin
            if (stat_i.range_err) begin
              cmd_o.plain      = 1'b1;
              cmd_o.plain_code = hmq_pkg::ST_RANGE;
            end else begin
              cmd_o.rd_grp = 1'b1;
              state_d      = S_RSEL;
            end
          end
          default: begin
            cmd_o.plain      = 1'b1;
            cmd_o.plain_code = hmq_pkg::ST_OK;
          end
        endcase
      end
      S_CMP: begin
        cmd_o.mrg_cmp = 1'b1;
        state_d       = S_PFX;
      end
      S_PFX: begin
        cmd_o.mrg_pfx = 1'b1;
        state_d       = S_INS;
      end
      S_INS: begin
        cmd_o.mrg_ins = 1'b1;
        state_d       = S_RESP;
      end
      S_RSEL: begin
        cmd_o.rd_sel = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        in_ready_o = stat_i.out_free;
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = S_DECODE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/hmq_dp.sv -----
// Datapath of the Huffman merge queue: shifting cell array, saturating
// adder, registered insert-position search, read tree, output register.
// Depends on hmq_pkg.
module hmq_dp #(
  parameter int unsigned MAX_LEAVES = hmq_pkg::MAX_LEAVES_DEF,
  parameter int unsigned COUNT_BITS = hmq_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hmq_pkg::hmq_cmd_t                 cmd_i,
  output hmq_pkg::hmq_stat_t                stat_o,
  input  logic [hmq_pkg::OP_W-1:0]          in_op_i,
  input  logic [hmq_pkg::SYM_W-1:0]         in_sym_i,
  input  logic [hmq_pkg::FREQ_W-1:0]        in_freq_i,
  input  logic [hmq_pkg::RIDX_W-1:0]        in_idx_i,
  output hmq_pkg::hmq_res_t                 res_o,
  output logic                              res_valid_o,
  input  logic                              res_ready_i
);

  localparam int unsigned NW   = hmq_pkg::NODE_W;
  localparam int unsigned LW   = hmq_pkg::LEN_W;
  localparam int unsigned FW   = hmq_pkg::FREQ_W;
  localparam int unsigned GRP  = hmq_pkg::GRP;
  localparam int unsigned GW   = hmq_pkg::GRP_W;
  localparam int unsigned NGRP = (MAX_LEAVES + GRP - 1) / GRP;
  localparam int unsigned PAD  = NGRP * GRP;
  localparam int unsigned EXT  = PAD + 2;

  // list cells
  logic [NW-1:0]         id_q  [MAX_LEAVES];
  logic [COUNT_BITS-1:0] cnt_q [MAX_LEAVES];
  logic [NW-1:0]         ext_id  [EXT];
  logic [COUNT_BITS-1:0] ext_cnt [EXT];

  // captured item
  logic [hmq_pkg::OP_W-1:0]   op_q;
  logic [hmq_pkg::SYM_W-1:0]  sym_q;
  logic [COUNT_BITS-1:0]      freq_q;
  logic [hmq_pkg::RIDX_W-1:0] idx_q;

  logic [LW-1:0]           total_q;
  logic [7:0]              ctr_q;
  logic [NW-1:0]           left_q, right_q, node_q;
  logic [COUNT_BITS-1:0]   sum_q;
  logic [COUNT_BITS:0]     sum_full;
  logic [COUNT_BITS-1:0]   sum_sat;

  logic [PAD-1:0]  gt_q, loc_q, loc_d;
  logic [NGRP-1:0] grp_q, grp_d, grp_prior;
  logic [PAD-1:0]  pfx, first;

  logic [NW-1:0]         rd_id_q  [NGRP];
  logic [COUNT_BITS-1:0] rd_cnt_q [NGRP];
  logic [NW-1:0]         rd_id_d  [NGRP];
  logic [COUNT_BITS-1:0] rd_cnt_d [NGRP];
  logic [NW-1:0]         sel_id;
  logic [COUNT_BITS-1:0] sel_cnt;

  hmq_pkg::hmq_res_t res_q, res_d, out_q;
  logic              out_valid_q;

  for (genvar k = 0; k < EXT; k++) begin : g_ext
    if (k < MAX_LEAVES) begin : g_cell
      assign ext_id[k]  = id_q[k];
      assign ext_cnt[k] = cnt_q[k];
    end else begin : g_pad
      assign ext_id[k]  = '0;
      assign ext_cnt[k] = '0;
    end
  end

  assign sum_full = {1'b0, ext_cnt[0]} + {1'b0, ext_cnt[1]};
  assign sum_sat  = sum_full[COUNT_BITS] ? '1 : sum_full[COUNT_BITS-1:0];

  // insert position: first cell past the two heads whose count exceeds the sum, or the list end
  always_comb begin
    logic acc;
    for (int g = 0; g < NGRP; g++) begin
      acc = 1'b0;
      for (int j = 0; j < GRP; j++) begin
        acc               = acc | gt_q[g*GRP + j];
        loc_d[g*GRP + j]  = acc;
      end
      grp_d[g] = acc;
    end
  end

  always_comb begin
    grp_prior[0] = 1'b0;
    for (int g = 1; g < NGRP; g++) begin
      grp_prior[g] = grp_prior[g-1] | grp_q[g-1];
    end
    for (int i = 0; i < PAD; i++) begin
      pfx[i] = loc_q[i] | grp_prior[i / GRP];
    end
    first[0] = pfx[0];
    for (int i = 1; i < PAD; i++) begin
      first[i] = pfx[i] & ~pfx[i-1];
    end
  end

  // two-level read tree
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      rd_id_d[g]  = '0;
      rd_cnt_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (idx_q[GW-1:0] == GW'(j)) begin
          rd_id_d[g]  = ext_id[g*GRP + j];
          rd_cnt_d[g] = ext_cnt[g*GRP + j];
        end
      end
    end
  end

  always_comb begin
    sel_id  = '0;
    sel_cnt = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (idx_q[hmq_pkg::RIDX_W-1:GW] == (hmq_pkg::RIDX_W - GW)'(g)) begin
        sel_id  = rd_id_q[g];
        sel_cnt = rd_cnt_q[g];
      end
    end
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.load) begin
      res_d        = '0;
      res_d.status = hmq_pkg::ST_OK;
      res_d.node   = NW'(sym_q);
      res_d.freq   = FW'(freq_q);
      res_d.length = total_q + LW'(1);
    end else if (cmd_i.plain) begin
      res_d        = '0;
      res_d.status = cmd_i.plain_code;
      res_d.length = total_q;
    end else if (cmd_i.mrg_ins) begin
      res_d.status = hmq_pkg::ST_OK;
      res_d.left   = left_q;
      res_d.right  = right_q;
      res_d.node   = node_q;
      res_d.freq   = FW'(sum_q);
      res_d.length = total_q - LW'(1);
      res_d.last   = (total_q == LW'(2));
    end else if (cmd_i.rd_sel) begin
      res_d        = '0;
      res_d.status = hmq_pkg::ST_OK;
      res_d.node   = sel_id;
      res_d.freq   = FW'(sel_cnt);
      res_d.length = total_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_op_i;
      sym_q  <= in_sym_i;
      freq_q <= COUNT_BITS'(in_freq_i);
      idx_q  <= in_idx_i;
    end
    if (cmd_i.mrg_sum) begin
      left_q  <= id_q[0];
      right_q <= id_q[1];
      sum_q   <= sum_sat;
      node_q  <= {1'b1, ctr_q};
    end
    if (cmd_i.mrg_cmp) begin
      for (int i = 0; i < PAD; i++) begin
        gt_q[i] <= ({1'b0, total_q} <= (LW+1)'(i + 2)) || (ext_cnt[i + 2] > sum_q);
      end
    end
    if (cmd_i.mrg_pfx) begin
      loc_q <= loc_d;
      grp_q <= grp_d;
    end
    if (cmd_i.rd_grp) begin
      for (int g = 0; g < NGRP; g++) begin
        rd_id_q[g]  <= rd_id_d[g];
        rd_cnt_q[g] <= rd_cnt_d[g];
      end
    end
    res_q <= res_d;
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  // cell array: append at tail, or drop two heads and insert the new node
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_LEAVES; i++) begin
      if (cmd_i.load && total_q == LW'(i)) begin
        id_q[i]  <= NW'(sym_q);
        cnt_q[i] <= freq_q;
      end else if (cmd_i.mrg_ins) begin
        if (!pfx[i]) begin
          id_q[i]  <= ext_id[i + 2];
          cnt_q[i] <= ext_cnt[i + 2];
        end else if (first[i]) begin
          id_q[i]  <= node_q;
          cnt_q[i] <= sum_q;
        end else begin
          id_q[i]  <= ext_id[i + 1];
          cnt_q[i] <= ext_cnt[i + 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        total_q <= total_q + LW'(1);
      end else if (cmd_i.mrg_ins) begin
        total_q <= total_q - LW'(1);
      end
      if (cmd_i.mrg_sum) begin
        ctr_q <= ctr_q + 8'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.full      = (total_q >= LW'(MAX_LEAVES));
  assign stat_o.few       = (total_q < LW'(2));
  assign stat_o.range_err = ({1'b0, idx_q} >= total_q);
  assign stat_o.out_free  = !out_valid_q || res_ready_i;

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

endmodule

// ----- test/hmq_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for huffman_merge_queue_unit: mirrors the ordered node list, predicts one
// result per accepted input item and compares results in order. Depends on hmq_pkg.
module hmq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // leaf_symbol, leaf_frequency, read_index
  input  logic [1:0]  s_axis_tuser,  // op
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,  // left_node, right_node, entry_node,
                                     // entry_frequency, list_length, zero pad
  input  logic [1:0]  m_axis_tuser,  // status
  input  logic        m_axis_tlast,  // last_merge
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned merges_o,
  output int unsigned err_status_o
);
  import hmq_pkg::*;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  logic [NODE_W-1:0] node_id  [MAX_LEAVES_DEF];
  logic [FREQ_W-1:0] node_cnt [MAX_LEAVES_DEF];
  int unsigned       node_total;
  logic [7:0]        merge_seq;
  hmq_res_t          tree_results_q[$];
  int unsigned       fails;
  int unsigned       checked;
  int unsigned       merges;
  int unsigned       err_status;

  function automatic hmq_res_t next_tree_result(input logic [OP_W-1:0] op,
                                                input logic [SYM_W-1:0] sym,
                                                input logic [FREQ_W-1:0] freq,
                                                input logic [RIDX_W-1:0] idx);
    hmq_res_t          r;
    logic [FREQ_W:0]   sum;
    logic [FREQ_W-1:0] merged;
    logic [NODE_W-1:0] new_id;
    int                remain;
    int                pos;
    r = '0;
    case (op)
      OP_LOAD: begin
        if (node_total >= MAX_LEAVES_DEF) begin
          r.status = ST_FULL;
        end else begin
          node_id[node_total]  = {1'b0, sym};
          node_cnt[node_total] = freq;
          node_total++;
          r.node = {1'b0, sym};
          r.freq = freq;
        end
      end
      OP_MERGE: begin
        if (node_total < 2) begin
          r.status = ST_FEW;
        end else begin
          r.left   = node_id[0];
          r.right  = node_id[1];
          sum      = {1'b0, node_cnt[0]} + {1'b0, node_cnt[1]};
          merged   = sum[FREQ_W] ? FREQ_MAX : sum[FREQ_W-1:0];
          new_id   = {1'b1, merge_seq};
          merge_seq++;
          remain   = node_total - 2;
          for (int i = 0; i < remain; i++) begin
            node_id[i]  = node_id[i+2];
            node_cnt[i] = node_cnt[i+2];
          end
          pos = 0;
          while (pos < remain && node_cnt[pos] <= merged) pos++;
          for (int i = remain; i > pos; i--) begin
            node_id[i]  = node_id[i-1];
            node_cnt[i] = node_cnt[i-1];
          end
          node_id[pos]  = new_id;
          node_cnt[pos] = merged;
          node_total    = remain + 1;
          r.node = new_id;
          r.freq = merged;
          r.last = (node_total == 1);
          merges++;
        end
      end
      OP_READ: begin
        if (idx >= node_total) begin
          r.status = ST_RANGE;
        end else begin
          r.node = node_id[idx];
          r.freq = node_cnt[idx];
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(node_total);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    hmq_res_t got;
    hmq_res_t want;
    if (!rst_ni) begin
      node_total = 0;
      merge_seq  = '0;
      tree_results_q.delete();
      fails      = 0;
      checked    = 0;
      merges     = 0;
      err_status = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.left   = m_axis_tdata[8:0];
        got.right  = m_axis_tdata[17:9];
        got.node   = m_axis_tdata[26:18];
        got.freq   = m_axis_tdata[58:27];
        got.length = m_axis_tdata[67:59];
        got.last   = m_axis_tlast;
        if (got.status != ST_OK) err_status++;
        if (tree_results_q.size() == 0) begin
          $error("result item with nothing expected");
          fails++;
        end else begin
          want = tree_results_q.pop_front();
          checked++;
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("left_node", 32'(want.left), 32'(got.left));
          check_field("right_node", 32'(want.right), 32'(got.right));
          check_field("entry_node", 32'(want.node), 32'(got.node));
          check_field("entry_frequency", want.freq, got.freq);
          check_field("list_length", 32'(want.length), 32'(got.length));
          check_field("last_merge", 32'(want.last), 32'(got.last));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tree_results_q.push_back(next_tree_result(s_axis_tuser, s_axis_tdata[7:0],
                                                  s_axis_tdata[39:8], s_axis_tdata[47:40]));
      end
    end
    fail_count_o <= fails;
    pending_o    <= tree_results_q.size();
    checked_o    <= checked;
    merges_o     <= merges;
    err_status_o <= err_status;
  end

endmodule

// ----- test/tb_huffman_merge_queue_unit.sv -----
`timescale 1ns / 1ps
// Top of the huffman_merge_queue_unit testbench: clock, reset, stimulus, back-pressure
// and verdict. Depends on hmq_pkg, huffman_merge_queue_unit and hmq_checker.
module tb_huffman_merge_queue_unit;
  import hmq_pkg::*;

  localparam logic [OP_W-1:0]   OP_SPARE     = 2'd3;
  localparam int unsigned       RANDOM_ITEMS = 1350;
  localparam logic [FREQ_W-1:0] FREQ_MAX     = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;  // leaf_symbol, leaf_frequency, read_index
  logic [1:0]  s_axis_tuser;  // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;  // left_node, right_node, entry_node,
                              // entry_frequency, list_length, zero pad
  logic [1:0]  m_axis_tuser;  // status
  logic        m_axis_tlast;  // last_merge

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned merges;
  int unsigned err_status;

  int unsigned       items_sent = 0;
  int unsigned       list_depth = 0;
  int unsigned       burst_left = 0;
  logic [FREQ_W-1:0] leaf_freq  = '0;

  always #5 clk_i = ~clk_i;

  huffman_merge_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  hmq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .merges_o      (merges),
    .err_status_o  (err_status)
  );

  initial begin
    #3_000_000;
    $display("tb_huffman_merge_queue_unit: done, errors");
    $finish;
  end

  // receiver: stall mode drawn at random from four modes, two long hold-offs
  initial begin : rx_side
    int unsigned rx_cycle;
    int unsigned hold_left;
    int unsigned mode;
    rx_cycle  = 0;
    hold_left = 0;
    mode      = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (rx_cycle % 97 == 0) mode = $urandom_range(0, 3);
      if (rx_cycle == 1500 || rx_cycle == 6000) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [FREQ_W-1:0] freq, input logic [RIDX_W-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {idx, freq, sym};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (op == OP_LOAD && list_depth < MAX_LEAVES_DEF) list_depth++;
    else if (op == OP_MERGE && list_depth >= 2) list_depth--;
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [RIDX_W-1:0] rand_index();
    case ($urandom_range(0, 3))
      0:       return RIDX_W'($urandom);
      1:       return RIDX_W'(list_depth);
      default: return (list_depth == 0) ? '0 : RIDX_W'($urandom_range(0, list_depth - 1));
    endcase
  endfunction

  // sorted load: count never decreases, clamps at the top
  task automatic load_leaf(input logic [FREQ_W-1:0] step);
    logic [FREQ_W:0] nxt;
    nxt       = {1'b0, leaf_freq} + {1'b0, step};
    leaf_freq = nxt[FREQ_W] ? FREQ_MAX : nxt[FREQ_W-1:0];
    push_item(OP_LOAD, SYM_W'($urandom), leaf_freq, RIDX_W'($urandom));
    if ($urandom_range(0, 4) == 0)
      push_item(OP_READ, SYM_W'($urandom), $urandom, rand_index());
  endtask

  task automatic merge_down();
    while (list_depth > 1) begin
      push_item(OP_MERGE, SYM_W'($urandom), $urandom, RIDX_W'($urandom));
      if ($urandom_range(0, 4) == 0)
        push_item(OP_READ, SYM_W'($urandom), $urandom, rand_index());
    end
  endtask

  initial begin : stimulus
    logic        fill_done;
    int unsigned directed_items;
    int unsigned kind;
    int unsigned n;
    int unsigned step_max;
    fill_done = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= OP_LOAD;
    s_axis_tdata  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, one entry, saturating sums, unsorted loads, spare op code
    push_item(OP_MERGE, 8'd0, '0, 8'd0);
    push_item(OP_READ, 8'd255, FREQ_MAX, 8'd0);
    push_item(OP_SPARE, 8'd255, FREQ_MAX, 8'd255);
    push_item(OP_LOAD, 8'd0, '0, 8'd0);
    push_item(OP_MERGE, 8'd0, '0, 8'd0);
    push_item(OP_READ, 8'd0, '0, 8'd0);
    push_item(OP_LOAD, 8'd255, FREQ_MAX, 8'd255);
    push_item(OP_READ, 8'd0, '0, 8'd1);
    push_item(OP_READ, 8'd0, '0, 8'd2);
    push_item(OP_READ, 8'd0, '0, 8'd255);
    push_item(OP_MERGE, 8'd255, FREQ_MAX, 8'd255);
    push_item(OP_LOAD, 8'd1, 32'h8000_0000, 8'd0);
    push_item(OP_LOAD, 8'd2, 32'h8000_0001, 8'd0);
    push_item(OP_MERGE, 8'd0, '0, 8'd0);
    push_item(OP_READ, 8'd0, '0, 8'd0);
    push_item(OP_READ, 8'd0, '0, 8'd1);
    push_item(OP_MERGE, 8'd0, '0, 8'd0);
    push_item(OP_LOAD, 8'd7, 32'd10, 8'd0);
    push_item(OP_LOAD, 8'd8, 32'd3, 8'd0);
    push_item(OP_LOAD, 8'd9, 32'd4, 8'd0);
    push_item(OP_MERGE, 8'd0, '0, 8'd0);
    push_item(OP_MERGE, 8'd0, '0, 8'd0);
    push_item(OP_MERGE, 8'd0, '0, 8'd0);
    push_item(OP_SPARE, SYM_W'($urandom), $urandom, RIDX_W'($urandom));
    pause_until_drained();
    directed_items = items_sent;

    while (items_sent < directed_items + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (!fill_done && items_sent > 400) begin
        // fill to capacity, bump into the full case, then merge down to the root
        leaf_freq = '0;
        while (list_depth < MAX_LEAVES_DEF) load_leaf($urandom_range(0, 3));
        push_item(OP_LOAD, SYM_W'($urandom), $urandom, RIDX_W'($urandom));
        push_item(OP_LOAD, SYM_W'($urandom), $urandom, RIDX_W'($urandom));
        push_item(OP_READ, SYM_W'($urandom), $urandom, 8'd255);
        merge_down();
        fill_done = 1'b1;
      end else if (kind < 8) begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(2, 12);
        case ($urandom_range(0, 3))
          0: begin
            leaf_freq = $urandom_range(0, 50);
            step_max  = 10;
          end
          1: begin
            leaf_freq = $urandom;
            step_max  = 32'h00FF_FFFF;
          end
          2: begin
            leaf_freq = FREQ_MAX - $urandom_range(0, 200);
            step_max  = 20;
          end
          default: begin
            leaf_freq = '0;
            step_max  = 1;
          end
        endcase
        repeat (n) load_leaf($urandom_range(0, step_max));
        merge_down();
        if ($urandom_range(0, 1) == 0)
          push_item(OP_MERGE, SYM_W'($urandom), $urandom, RIDX_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 8))
          push_item(OP_W'($urandom), SYM_W'($urandom), $urandom, RIDX_W'($urandom));
      end
      if ($urandom_range(0, 5) == 0) pause_until_drained();
    end

    pause_until_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d input items, %0d results checked, %0d merges, %0d error statuses",
             items_sent, checked, merges, err_status);
    if (fail_count == 0) begin
      $display("tb_huffman_merge_queue_unit: done, clean");
    end else begin
      $display("tb_huffman_merge_queue_unit: done, errors");
    end
    $finish;
  end

endmodule
